// ----- rtl/core/wildcard_pattern_matcher_unit_assert.svh -----
// Assertion macros for the matcher RTL.
`ifndef WILDCARD_PATTERN_MATCHER_UNIT_ASSERT_SVH
`define WILDCARD_PATTERN_MATCHER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/wpm_pkg.sv -----
package wpm_pkg;

    // Wildcard symbols in the pattern.
    localparam logic [7:0] SYM_ANY_ONE = 8'd63;
    localparam logic [7:0] SYM_ANY_RUN = 8'd42;

    // Request types.
    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_TEXT    = 1'b1;

    // Default pattern store capacity and the width of the length field.
    localparam int MAX_PATTERN_DEF = 32;
    localparam int LEN_W           = 6;

    typedef struct packed {
        logic       req_type;
        logic       first;
        logic [7:0] symbol;
    } t_wpm_in;

    typedef struct packed {
        logic             matched;
        logic             pattern_overflow;
        logic [LEN_W-1:0] pattern_length;
    } t_wpm_out;

    // Text token that walks down the cell chain.
    typedef struct packed {
        logic       valid;
        logic [7:0] sym;
        logic       carry;
        logic       old;
    } t_wpm_tok;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic       upd;
        logic       clr;
        logic       reload;
        logic [7:0] sym;
    } t_wpm_ctl;

endpackage

// ----- rtl/core/wpm_cell.sv -----
module wpm_cell
    import wpm_pkg::*;
#(
    parameter int MAX_PAT = MAX_PATTERN_DEF,
    parameter int IDX     = 1,
    localparam int CW     = $clog2(MAX_PAT + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_wpm_ctl      i_ctl,
    input  logic [CW-1:0] i_count,
    input  logic [CW-1:0] i_base,
    input  logic          i_left_e,
    input  t_wpm_tok      i_tok,
    output logic          o_e,
    output logic          o_m,
    output t_wpm_tok      o_tok
);

    logic [7:0] r_pat;
    logic       r_e;
    logic       r_m;
    t_wpm_tok   r_tok;
    logic       w_active;
    logic       w_hit;
    logic       n_e;
    logic       n_step;

    // This cell holds pattern position IDX; it only takes part when the pattern reaches it.
    assign w_active = (CW'(IDX) <= i_count);
    assign w_hit    = (i_base == CW'(IDX - 1));

    // Empty-text bit for a pattern update: written on append, cleared on a new pattern.
    always_comb begin
        if (w_hit) begin
            n_e = i_left_e && (i_ctl.sym == SYM_ANY_RUN);
        end else if (i_ctl.clr) begin
            n_e = 1'b0;
        end else begin
            n_e = r_e;
        end
    end

    // One step of the match recurrence for the passing text byte.
    always_comb begin
        if ((r_pat == i_tok.sym) || (r_pat == SYM_ANY_ONE)) begin
            n_step = i_tok.old;
        end else if (r_pat == SYM_ANY_RUN) begin
            n_step = i_tok.carry || r_m;
        end else begin
            n_step = 1'b0;
        end
    end

    // Pattern byte storage.
    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && w_hit) begin
            r_pat <= i_ctl.sym;
        end
    end

    // Row bits and the token handed to the next cell.
    // The token payload carries the new bit and this cell's previous bit onward.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e       <= 1'b0;
            r_m       <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            if (i_ctl.upd) begin
                r_e <= n_e;
                r_m <= n_e;
            end else if (i_ctl.reload) begin
                r_m <= r_e;
            end else if (i_tok.valid && w_active) begin
                r_m <= n_step;
            end
            r_tok.valid <= i_tok.valid && w_active;
        end
        r_tok.sym   <= i_tok.sym;
        r_tok.carry <= n_step;
        r_tok.old   <= r_m;
    end

    assign o_e   = r_e;
    assign o_m   = r_m;
    assign o_tok = r_tok;

endmodule

// ----- rtl/core/wildcard_pattern_matcher_unit.sv -----
// A pattern byte is taken in the idle state and its result is loaded into the output register from
// the done state; a text byte first walks down the active cells, one cell per cycle, before that.
// The unit takes no new byte until the result of the last one is loaded into the output register.
// The sweep down the cell chain sets the text rate.
// Reset (synchronous, active low) empties the pattern and the rows; no clearing pass.
module wildcard_pattern_matcher_unit
    import wpm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_wpm_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_wpm_out o_out_data
);

    `include "wildcard_pattern_matcher_unit_assert.svh"

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]             r_st;
    logic [1:0]             n_st;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_left;
    logic                   r_ovf;
    logic                   r_m0;
    t_wpm_tok               r_tok;
    logic                   r_ov;
    t_wpm_out               r_out;
    t_wpm_ctl               w_ctl;
    logic                   w_accept;
    logic                   w_is_pat;
    logic                   w_full;
    logic                   w_load;
    logic                   w_matched;
    logic [CW-1:0]          w_base;
    logic [MAX_PATTERN-1:0] w_e;
    logic [MAX_PATTERN-1:0] w_m;
    logic [MAX_PATTERN-1:0] w_tokv;
    t_wpm_tok               w_tok [MAX_PATTERN];

    // Input handshake and decode of the transaction.
    assign o_in_stall = (r_st != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_is_pat   = (i_in_data.req_type == REQ_PATTERN);
    assign w_base     = i_in_data.first ? '0 : r_count;
    assign w_full     = (w_base >= CW'(MAX_PATTERN));

    // Broadcast control for the cells.
    always_comb begin
        w_ctl.upd    = w_accept && w_is_pat && !w_full;
        w_ctl.clr    = w_accept && w_is_pat && i_in_data.first;
        w_ctl.reload = w_accept && !w_is_pat && i_in_data.first;
        w_ctl.sym    = i_in_data.symbol;
    end

    // Chain of pattern cells, position k held by cell k-1 of the array.
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic     w_left_e;
        t_wpm_tok w_tin;

        if (k == 0) begin : g_head
            assign w_left_e = 1'b1;
            assign w_tin    = r_tok;
        end else begin : g_body
            assign w_left_e = w_e[k-1];
            assign w_tin    = w_tok[k-1];
        end

        wpm_cell #(
            .MAX_PAT (MAX_PATTERN),
            .IDX     (k + 1)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_count  (r_count),
            .i_base   (w_base),
            .i_left_e (w_left_e),
            .i_tok    (w_tin),
            .o_e      (w_e[k]),
            .o_m      (w_m[k]),
            .o_tok    (w_tok[k])
        );

        assign w_tokv[k] = w_tok[k].valid;
    end

    // Pattern length, overflow flag and match bit zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_m0    <= 1'b1;
        end else if (w_accept) begin
            if (w_is_pat) begin
                if (i_in_data.first) begin
                    r_ovf <= 1'b0;
                end
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= w_base + CW'(1);
                    r_m0    <= 1'b1;
                end
            end else begin
                r_m0 <= 1'b0;
            end
        end
    end

    // Launch a text byte into the first cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= w_accept && !w_is_pat;
        end
        r_tok.sym   <= i_in_data.symbol;
        r_tok.carry <= 1'b0;
        r_tok.old   <= i_in_data.first ? 1'b1 : r_m0;
    end

    // Sequencer: wait for the token to reach the last active cell.
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (w_accept) begin
                    n_st = (!w_is_pat && (r_count != '0)) ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN: begin
                if (r_left == CW'(1)) begin
                    n_st = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_st = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_left <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_IDLE) begin
                r_left <= r_count;
            end else if (r_st == ST_RUN) begin
                r_left <= r_left - CW'(1);
            end
        end
    end

    // Result register, loaded when the previous result is gone or leaving.
    assign w_load    = (r_st == ST_DONE) && (!r_ov || !i_out_stall);
    assign w_matched = (r_count == '0) ? r_m0 : w_m[IW'(r_count - CW'(1))];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.matched          <= w_matched;
            r_out.pattern_overflow <= r_ovf;
            r_out.pattern_length   <= LEN_W'(r_count);
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // Checks on the sequencer and the chain.
    `WPM_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_PATTERN), "pattern count beyond capacity")
    `WPM_ASSERT_NOW(a_run_left, i_clk, i_rst_n, r_st == ST_RUN, (r_left != '0) && (r_left <= r_count), "sweep counter out of range")
    `WPM_ASSERT_NOW(a_idle_quiet, i_clk, i_rst_n, r_st == ST_IDLE, (w_tokv == '0) && !r_tok.valid, "text token in flight while idle")
    `WPM_ASSERT_NEXT(a_new_pattern, i_clk, i_rst_n, w_accept && w_is_pat && i_in_data.first, r_count == CW'(1), "new pattern did not restart length")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import wpm_pkg::*;

    localparam int PAT_DEPTH   = MAX_PATTERN_DEF;
    localparam int MAX_REPORTS = 10;

    // Receiver stall modes.
    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_HOLD   = 2;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_wpm_in  in_data;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_wpm_out out_data;

    // Matcher state as the checker sees it.
    logic [7:0]         pat_mem [PAT_DEPTH];
    int unsigned        pat_cnt;
    logic [PAT_DEPTH:0] text_row;
    logic [PAT_DEPTH:0] empty_row;
    logic               ovf_flag;

    t_wpm_out match_results_q[$];
    int       err_cnt    = 0;
    int       burst_left = 0;
    int       stall_run  = 0;
    int       stall_mode = STALL_NONE;

    wildcard_pattern_matcher_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    // 100 MHz clock.
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Update the match state for one transaction and return the result it should give.
    function automatic t_wpm_out predict_match(input t_wpm_in req);
        logic [PAT_DEPTH:0] next_row;
        logic [7:0]         p;
        t_wpm_out           res;
        if (req.req_type == REQ_TEXT) begin
            if (req.first) begin
                text_row = empty_row;
            end
            next_row = '0;
            for (int j = 1; j <= pat_cnt; j++) begin
                p = pat_mem[j-1];
                if (p == req.symbol || p == SYM_ANY_ONE) begin
                    next_row[j] = text_row[j-1];
                end else if (p == SYM_ANY_RUN) begin
                    next_row[j] = next_row[j-1] | text_row[j];
                end
            end
            text_row = next_row;
        end else begin
            if (req.first) begin
                pat_cnt   = 0;
                ovf_flag  = 1'b0;
                text_row  = 1;
                empty_row = 1;
            end
            if (pat_cnt >= PAT_DEPTH) begin
                // Store full: the byte is dropped and nothing else moves.
                ovf_flag = 1'b1;
            end else begin
                pat_mem[pat_cnt]     = req.symbol;
                empty_row[pat_cnt+1] = empty_row[pat_cnt] & (req.symbol == SYM_ANY_RUN);
                pat_cnt++;
                text_row = empty_row;
            end
        end
        res.matched          = text_row[pat_cnt];
        res.pattern_overflow = ovf_flag;
        res.pattern_length   = LEN_W'(pat_cnt);
        return res;
    endfunction

    // Record accepted requests and check each accepted result against the oldest prediction.
    always @(posedge clk) begin : monitor
        t_wpm_out want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                match_results_q.push_back(predict_match(in_data));
            end
            if (out_valid && !out_stall) begin
                if (match_results_q.size() == 0) begin
                    if (err_cnt < MAX_REPORTS) begin
                        $display("%0t: unexpected result matched=%0b overflow=%0b length=%0d",
                                 $realtime, out_data.matched, out_data.pattern_overflow,
                                 out_data.pattern_length);
                    end
                    err_cnt++;
                end else begin
                    want = match_results_q.pop_front();
                    if (out_data.matched !== want.matched ||
                        out_data.pattern_overflow !== want.pattern_overflow ||
                        out_data.pattern_length !== want.pattern_length) begin
                        if (err_cnt < MAX_REPORTS) begin
                            $display("%0t: expected matched=%0b overflow=%0b length=%0d, %s",
                                     $realtime, want.matched, want.pattern_overflow,
                                     want.pattern_length, "got:");
                            $display("    matched=%0b overflow=%0b length=%0d",
                                     out_data.matched, out_data.pattern_overflow,
                                     out_data.pattern_length);
                        end
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Receiver stall pattern: open stretches, random stalls, and held stalls.
    always @(negedge clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_HOLD);
            stall_run  = (stall_mode == STALL_HOLD) ? $urandom_range(1, 12)
                                                    : $urandom_range(10, 120);
        end
        stall_run--;
        case (stall_mode)
            STALL_NONE:   out_stall = 1'b0;
            STALL_RANDOM: out_stall = 1'($urandom_range(0, 1));
            default:      out_stall = 1'b1;
        endcase
    end

    // Send one transaction; the sender works in bursts with random gaps between them.
    task automatic send_item(input logic rtype, input logic first, input logic [7:0] sym);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid         = 1'b1;
        in_data.req_type = rtype;
        in_data.first    = first;
        in_data.symbol   = sym;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Pattern symbols drawn mostly from a small alphabet and the wildcards.
    function automatic logic [7:0] pick_pattern_sym();
        int r;
        r = $urandom_range(0, 15);
        if (r < 8) begin
            return 8'h61 + 8'($urandom_range(0, 2));
        end
        if (r < 10) begin
            return SYM_ANY_ONE;
        end
        if (r < 13) begin
            return SYM_ANY_RUN;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_text_sym();
        if ($urandom_range(0, 15) < 13) begin
            return 8'h61 + 8'($urandom_range(0, 2));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // No pattern loaded yet: only the empty text matches.
    task automatic test_empty_pattern();
        send_item(REQ_TEXT, 1'b0, 8'h00);
        send_item(REQ_TEXT, 1'b1, 8'hFF);
    endtask

    // Pattern with both byte extremes around the two wildcards.
    task automatic test_wildcard_symbols();
        send_item(REQ_PATTERN, 1'b1, 8'h00);
        send_item(REQ_PATTERN, 1'b0, SYM_ANY_ONE);
        send_item(REQ_PATTERN, 1'b0, SYM_ANY_RUN);
        send_item(REQ_PATTERN, 1'b0, 8'hFF);
        // The run matches nothing here.
        send_item(REQ_TEXT, 1'b1, 8'h00);
        send_item(REQ_TEXT, 1'b0, 8'h80);
        send_item(REQ_TEXT, 1'b0, 8'hFF);
        // The run matches one byte.
        send_item(REQ_TEXT, 1'b1, 8'h00);
        send_item(REQ_TEXT, 1'b0, 8'h01);
        send_item(REQ_TEXT, 1'b0, 8'h02);
        send_item(REQ_TEXT, 1'b0, 8'hFF);
        // Too short for the single-byte wildcard.
        send_item(REQ_TEXT, 1'b1, 8'h00);
        send_item(REQ_TEXT, 1'b0, 8'hFF);
    endtask

    // All-run pattern matches the empty text; a pattern byte mid-text restarts the text.
    task automatic test_star_pattern();
        send_item(REQ_PATTERN, 1'b1, SYM_ANY_RUN);
        send_item(REQ_PATTERN, 1'b0, SYM_ANY_RUN);
        send_item(REQ_TEXT, 1'b1, SYM_ANY_ONE);
        send_item(REQ_PATTERN, 1'b0, SYM_ANY_ONE);
        send_item(REQ_TEXT, 1'b0, SYM_ANY_RUN);
    endtask

    // Fill the store, then show that dropped bytes leave the rows and the text alone.
    task automatic test_store_full();
        for (int i = 0; i < PAT_DEPTH; i++) begin
            send_item(REQ_PATTERN, i == 0, (i == PAT_DEPTH - 1) ? 8'h7A : SYM_ANY_RUN);
        end
        send_item(REQ_PATTERN, 1'b0, 8'h71);
        send_item(REQ_TEXT, 1'b1, 8'h7A);
        send_item(REQ_PATTERN, 1'b0, SYM_ANY_ONE);
        send_item(REQ_TEXT, 1'b0, 8'h79);
        // A new pattern clears the overflow flag.
        send_item(REQ_PATTERN, 1'b1, SYM_ANY_RUN);
    endtask

    // Random patterns followed by texts, many built to match, with some noise mixed in.
    task automatic test_random_traffic(input int target);
        logic [7:0] pat[$];
        logic [7:0] txt[$];
        logic [7:0] sym;
        int         sent;
        int         len;
        int         n;
        int         r;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                // Noise: any field combination, including broken sequences.
                n = $urandom_range(1, 6);
                repeat (n) begin
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)));
                end
                sent += n;
            end else begin
                // Mostly short patterns; a few fill or overflow the store.
                r = $urandom_range(0, 19);
                if (r < 14) begin
                    len = $urandom_range(1, 6);
                end else if (r < 18) begin
                    len = $urandom_range(7, 20);
                end else if (r == 18) begin
                    len = $urandom_range(21, PAT_DEPTH);
                end else begin
                    len = $urandom_range(PAT_DEPTH + 1, PAT_DEPTH + 4);
                end
                pat.delete();
                for (int i = 0; i < len; i++) begin
                    sym = pick_pattern_sym();
                    send_item(REQ_PATTERN, i == 0, sym);
                    if (pat.size() < PAT_DEPTH) begin
                        pat.push_back(sym);
                    end
                end
                sent += len;
                repeat ($urandom_range(1, 4)) begin
                    txt.delete();
                    if ($urandom_range(0, 1) == 1) begin
                        // Expand the pattern into a matching text, sometimes corrupted.
                        foreach (pat[k]) begin
                            if (pat[k] == SYM_ANY_RUN) begin
                                repeat ($urandom_range(0, 3)) txt.push_back(pick_text_sym());
                            end else if (pat[k] == SYM_ANY_ONE) begin
                                txt.push_back(pick_text_sym());
                            end else begin
                                txt.push_back(pat[k]);
                            end
                        end
                        if (txt.size() > 0 && $urandom_range(0, 3) == 0) begin
                            txt[$urandom_range(0, txt.size() - 1)] = pick_text_sym();
                        end
                    end else begin
                        repeat ($urandom_range(0, 10)) txt.push_back(pick_text_sym());
                    end
                    foreach (txt[k]) begin
                        // Now and then the pattern grows in the middle of a text.
                        if ($urandom_range(0, 15) == 0) begin
                            sym = pick_pattern_sym();
                            send_item(REQ_PATTERN, 1'b0, sym);
                            if (pat.size() < PAT_DEPTH) begin
                                pat.push_back(sym);
                            end
                            sent++;
                        end
                        send_item(REQ_TEXT, (k == 0) && ($urandom_range(0, 3) != 0), txt[k]);
                    end
                    sent += txt.size();
                end
            end
        end
    endtask

    // Wait for every predicted result, then a little longer for strays.
    task automatic drain_results();
        int waited;
        in_valid = 1'b0;
        waited   = 0;
        while (match_results_q.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (match_results_q.size() != 0) begin
            $display("%0d results never arrived", match_results_q.size());
            err_cnt += match_results_q.size();
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        pat_cnt   = 0;
        ovf_flag  = 1'b0;
        text_row  = 1;
        empty_row = 1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_pattern();
        test_wildcard_symbols();
        test_star_pattern();
        test_store_full();
        test_random_traffic(1900);
        drain_results();

        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
